>>> rtl/rrs_pkg.sv
// shared types and constants for the running reduce block
package rrs_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int ACC_W = 64;
    localparam int CNT_W = 7;

    localparam logic [2:0] OP_SUM = 3'd0;
    localparam logic [2:0] OP_MIN = 3'd1;
    localparam logic [2:0] OP_MAX = 3'd2;
    localparam logic [2:0] OP_GCD = 3'd3;
    localparam logic [2:0] OP_LCM = 3'd4;

    localparam logic CFG_OP_MODE = 1'b0;
    localparam logic CFG_INIT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture request operands
        logic simple;    // compute sum/min/max/pass result
        logic gcd_step;  // one euclid swap after a finished remainder
        logic div_init;  // start a restoring division a / b
        logic lcm_init;  // start a restoring division ma / gcd
        logic div_step;  // one quotient bit
        logic mul_init;  // start lcm multiply q * mb
        logic mul_step;  // one multiplier bit
        logic fin_gcd;
        logic fin_lcm;
        logic fin_zero;
    } rrs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic b_zero;
        logic mag_zero;
        logic div_done;
        logic mul_done;
    } rrs_sts_t;
endpackage

>>> rtl/rrs_datapath.sv
// accumulator, euclid divider and serial multiplier
module rrs_datapath
    import rrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rrs_cmd_t               cmd,
    output rrs_sts_t               sts,
    input  logic [2:0]             op_mode,
    input  logic [ACC_W-1:0]       init_value,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   last_in,
    output logic [ACC_W-1:0]       result,
    output logic                   overflow,
    output logic                   last_out
);
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             start_reg, start_next;
    logic [ACC_W-1:0] prev_reg, v_reg;
    logic [ACC_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [ACC_W-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [ACC_W-1:0] quo_reg, quo_next, rem_reg, rem_next;
    logic [ACC_W-1:0] prod_reg, prod_next;
    logic             povf_reg, povf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] res_reg, res_next;
    logic             ovf_reg, ovf_next, lst_reg, lst_next;

    logic [ACC_W-1:0] v_ext, prev_sel, sum, mag_p, mag_v;
    logic [ACC_W:0]   rem_sh, rem_sub;
    logic [ACC_W:0]   padd;

    assign v_ext = {{(ACC_W-VALUE_WIDTH){value[VALUE_WIDTH-1]}}, value};
    assign prev_sel = start_reg ? init_value : acc_reg;
    assign mag_p = prev_sel[ACC_W-1] ? (~prev_sel + 1'b1) : prev_sel;
    assign mag_v = v_ext[ACC_W-1] ? (~v_ext + 1'b1) : v_ext;
    assign sum = prev_reg + v_reg;
    assign rem_sh = {rem_reg, quo_reg[ACC_W-1]};
    assign rem_sub = rem_sh - {1'b0, b_reg};

    assign sts.b_zero = (b_reg == '0);
    assign sts.mag_zero = (ma_reg == '0) || (mb_reg == '0);
    assign sts.div_done = (cnt_reg == '0);
    assign sts.mul_done = (cnt_reg == '0);

    always_comb
    begin
        acc_next = acc_reg; start_next = start_reg;
        a_next = a_reg; b_next = b_reg; ma_next = ma_reg; mb_next = mb_reg;
        quo_next = quo_reg; rem_next = rem_reg; prod_next = prod_reg;
        povf_next = povf_reg; cnt_next = cnt_reg;
        res_next = res_reg; ovf_next = ovf_reg; lst_next = lst_reg;
        padd = '0;
        if (cmd.load)
        begin
            a_next = mag_p; b_next = mag_v;
            ma_next = mag_p; mb_next = mag_v;
            lst_next = last_in;
        end
        if (cmd.simple)
        begin
            ovf_next = 1'b0;
            unique case (op_mode)
                OP_SUM:
                begin
                    res_next = sum;
                    if (prev_reg[ACC_W-1] == v_reg[ACC_W-1] &&
                        sum[ACC_W-1] != prev_reg[ACC_W-1])
                    begin
                        ovf_next = 1'b1;
                        res_next = prev_reg[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                     : {1'b0, {(ACC_W-1){1'b1}}};
                    end
                end
                OP_MIN: res_next = ($signed(prev_reg) < $signed(v_reg)) ? prev_reg : v_reg;
                OP_MAX: res_next = ($signed(prev_reg) > $signed(v_reg)) ? prev_reg : v_reg;
                default: res_next = prev_reg;
            endcase
        end
        if (cmd.div_init)
        begin
            quo_next = a_reg; rem_next = '0;
            cnt_next = CNT_W'(ACC_W);
        end
        if (cmd.lcm_init)
        begin
            // dividend ma, divisor the gcd left in a
            quo_next = ma_reg; rem_next = '0; b_next = a_reg;
            cnt_next = CNT_W'(ACC_W);
        end
        if (cmd.div_step)
        begin
            if (!rem_sub[ACC_W])
                rem_next = rem_sub[ACC_W-1:0];
            else
                rem_next = rem_sh[ACC_W-1:0];
            quo_next = {quo_reg[ACC_W-2:0], !rem_sub[ACC_W]};
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.gcd_step)
        begin
            a_next = b_reg; b_next = rem_reg;
        end
        if (cmd.mul_init)
        begin
            // quotient ma / g sits in quo_reg; shift it out msb first
            prod_next = '0; povf_next = 1'b0;
            cnt_next = CNT_W'(ACC_W);
        end
        if (cmd.mul_step)
        begin
            logic [ACC_W-1:0] dbl;
            logic dovf;
            dbl = {prod_reg[ACC_W-2:0], 1'b0};
            dovf = prod_reg[ACC_W-1];
            prod_next = dbl;
            if (quo_reg[ACC_W-1])
            begin
                padd = {1'b0, dbl} + {1'b0, mb_reg};
                prod_next = padd[ACC_W-1:0];
                dovf = dovf | padd[ACC_W];
            end
            povf_next = povf_reg | dovf;
            quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.fin_gcd)
        begin
            ovf_next = a_reg[ACC_W-1];
            res_next = a_reg[ACC_W-1] ? {1'b0, {(ACC_W-1){1'b1}}} : a_reg;
        end
        if (cmd.fin_lcm)
        begin
            ovf_next = povf_reg | prod_reg[ACC_W-1];
            res_next = ovf_next ? {1'b0, {(ACC_W-1){1'b1}}} : prod_reg;
        end
        if (cmd.fin_zero)
        begin
            ovf_next = 1'b0; res_next = '0;
        end
        if (cmd.simple || cmd.fin_gcd || cmd.fin_lcm || cmd.fin_zero)
        begin
            acc_next = res_next;
            start_next = lst_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            start_reg <= 1'b1;
        end
        else
        begin
            acc_reg <= acc_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            prev_reg <= prev_sel;
            v_reg <= v_ext;
        end
        a_reg <= a_next; b_reg <= b_next; ma_reg <= ma_next; mb_reg <= mb_next;
        quo_reg <= quo_next; rem_reg <= rem_next; prod_reg <= prod_next;
        povf_reg <= povf_next; cnt_reg <= cnt_next;
        res_reg <= res_next; ovf_reg <= ovf_next; lst_reg <= lst_next;
    end

    assign result = res_reg;
    assign overflow = ovf_reg;
    assign last_out = lst_reg;
endmodule

>>> rtl/rrs_ctrl.sv
// sequencing of the euclid, divide and multiply steps
module rrs_ctrl
    import rrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] op_mode,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  rrs_sts_t   sts,
    output rrs_cmd_t   cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_GCHK = 4'd2;
    localparam logic [3:0] S_GDIV = 4'd3;
    localparam logic [3:0] S_LQ0  = 4'd4;
    localparam logic [3:0] S_LQ   = 4'd5;
    localparam logic [3:0] S_LM   = 4'd6;
    localparam logic [3:0] S_OUT  = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       lcm_reg, lcm_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        lcm_next = lcm_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DISP;
                end
            S_DISP:
                if (op_mode == OP_GCD)
                begin
                    lcm_next = 1'b0;
                    state_next = S_GCHK;
                end
                else if (op_mode == OP_LCM)
                begin
                    lcm_next = 1'b1;
                    if (sts.mag_zero)
                    begin
                        cmd.fin_zero = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_GCHK;
                end
                else
                begin
                    cmd.simple = 1'b1;
                    state_next = S_OUT;
                end
            S_GCHK:
                if (sts.b_zero)
                begin
                    if (lcm_reg)
                        state_next = S_LQ0;
                    else
                    begin
                        cmd.fin_gcd = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next = S_GDIV;
                end
            S_GDIV:
                if (sts.div_done)
                begin
                    cmd.gcd_step = 1'b1;
                    state_next = S_GCHK;
                end
                else
                    cmd.div_step = 1'b1;
            S_LQ0:
            begin
                // divide ma by the gcd, held in a
                cmd.lcm_init = 1'b1;
                state_next = S_LQ;
            end
            S_LQ:
                if (sts.div_done)
                begin
                    cmd.mul_init = 1'b1;
                    state_next = S_LM;
                end
                else
                    cmd.div_step = 1'b1;
            S_LM:
                if (sts.mul_done)
                begin
                    cmd.fin_lcm = 1'b1;
                    state_next = S_OUT;
                end
                else
                    cmd.mul_step = 1'b1;
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lcm_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lcm_reg <= lcm_next;
        end
    end
endmodule

>>> rtl/running_reduce_sum_min_max_gcd_lcm.sv
// top level: running reduction with selectable operator
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  value, last_in
//   out      output     out_valid/out_stall result, overflow, last_out
//   cfg      input      cfg_we             cfg_index, cfg_data
// sum, min, max: load, compute, then output wait
// gcd: each euclid step is a full restoring division, euclid steps data dependent
// lcm: the gcd, then the division ma/g, then the serial multiply
// one request in flight; the shared 64-step restoring divider sets the time
// reset clears the accumulator and starts a new sequence from init_value
// a stalled result holds and no new request is taken until it leaves
module running_reduce_sum_min_max_gcd_lcm
    import rrs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [ACC_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   last_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [ACC_W-1:0]       result,
    output logic                   overflow,
    output logic                   last_out
);
    logic [2:0]       op_reg;
    logic [ACC_W-1:0] init_reg;
    rrs_cmd_t         cmd;
    rrs_sts_t         sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_SUM;
            init_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OP_MODE: op_reg <= cfg_data[2:0];
                CFG_INIT:    init_reg <= cfg_data;
            endcase
        end
    end

    rrs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .op_mode(op_reg),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .sts(sts), .cmd(cmd)
    );

    rrs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .op_mode(op_reg), .init_value(init_reg),
        .value(value), .last_in(last_in),
        .result(result), .overflow(overflow), .last_out(last_out)
    );
endmodule

>>> rtl/rrs_checker.sv
// port-level checks for the running reduce block
module rrs_checker
    import rrs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ACC_W-1:0] result,
    input logic             overflow
);
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("request taken while result pending");
    a_no_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result)))
        else $error("stalled result changed");
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
        (result == {1'b0, {(ACC_W-1){1'b1}}} || result == {1'b1, {(ACC_W-1){1'b0}}}))
        else $error("overflow without saturated result");
endmodule

bind running_reduce_sum_min_max_gcd_lcm rrs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .overflow(overflow)
);
